>>> rtl/core/ebalu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ebalu_pkg;

  // operation codes carried in req_type
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_DAA   = 5'd10,
    OP_CPL   = 5'd11,
    OP_SCF   = 5'd12,
    OP_CCF   = 5'd13,
    OP_RLCA  = 5'd14,
    OP_RRCA  = 5'd15,
    OP_RLA   = 5'd16,
    OP_RRA   = 5'd17,
    OP_RLC   = 5'd18,
    OP_RRC   = 5'd19,
    OP_RL    = 5'd20,
    OP_RR    = 5'd21,
    OP_SLA   = 5'd22,
    OP_SRA   = 5'd23,
    OP_SWAP  = 5'd24,
    OP_SRL   = 5'd25,
    OP_BIT   = 5'd26,
    OP_RES   = 5'd27,
    OP_SET   = 5'd28,
    OP_ADD16 = 5'd29
  } op_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [7:0]  acc_value;
    logic [7:0]  src_value;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
    logic [15:0] wide_dest;
    logic [15:0] wide_src;
  } req_t;

  typedef struct packed {
    logic [7:0]  result_value;
    logic [15:0] wide_result;
    logic [3:0]  flags_out;
    logic        writes_back;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/eight_bit_alu_with_flags.sv
// path: an accepted input word is held in the input register, then its result
//   is loaded into the result register and shown on the outputs
// throughput: one word per cycle while out_ready is high, set by the single-pass
//   datapath between the input register and the result register
// reset: synchronous active-high rst empties both registers; no result is
//   shown and any word in flight is dropped
`timescale 1ns / 1ps
`default_nettype none

module eight_bit_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  req_type,
  input  wire logic [7:0]  acc_value,
  input  wire logic [7:0]  src_value,
  input  wire logic [2:0]  bit_index,
  input  wire logic [3:0]  flags_in,
  input  wire logic [15:0] wide_dest,
  input  wire logic [15:0] wide_src,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       result_value,
  output logic [15:0]      wide_result,
  output logic [3:0]       flags_out,
  output logic             writes_back
);
  import ebalu_pkg::*;

  req_t in_word;
  req_t hold_word;
  rsp_t exec_word;
  rsp_t out_word;
  logic hold_valid;
  logic hold_take;

  // pack the input ports into one word
  always_comb begin
    in_word.req_type  = req_type;
    in_word.acc_value = acc_value;
    in_word.src_value = src_value;
    in_word.bit_index = bit_index;
    in_word.flags_in  = flags_in;
    in_word.wide_dest = wide_dest;
    in_word.wide_src  = wide_src;
  end

  // input register: takes a new word whenever it is empty or the held word moves on
  ebalu_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .hold_valid (hold_valid),
    .hold_take  (hold_take),
    .hold_word  (hold_word)
  );

  // all arithmetic, logic, shift and flag work in one combinational pass
  ebalu_exec u_exec (
    .req (hold_word),
    .rsp (exec_word)
  );

  // result register: loads while empty or while its word is taken
  ebalu_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (hold_valid),
    .load_take  (hold_take),
    .load_word  (exec_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // unpack the result word onto the ports
  assign result_value = out_word.result_value;
  assign wide_result  = out_word.wide_result;
  assign flags_out    = out_word.flags_out;
  assign writes_back  = out_word.writes_back;

endmodule

`default_nettype wire

>>> rtl/core/ebalu_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ebalu_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ebalu_pkg::req_t in_word,
  output logic               hold_valid,
  input  wire logic          hold_take,
  output ebalu_pkg::req_t    hold_word
);
  import ebalu_pkg::*;

  logic hold_valid_next;

  // accept whenever the stage is empty or its word moves on this cycle
  assign in_ready = !hold_valid || hold_take;

  always_comb begin
    hold_valid_next = hold_valid;
    if (in_ready) begin
      hold_valid_next = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_word <= in_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ebalu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module ebalu_exec (
  input  wire ebalu_pkg::req_t req,
  output ebalu_pkg::rsp_t      rsp
);
  import ebalu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        zf;
  logic        nf;
  logic        hf;
  logic        cf;
  logic        ci_adc;
  logic        ci_sbc;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  diff9;
  logic [4:0]  diff_lo;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  daa_up;
  logic [7:0]  daa_dn;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [7:0]  bit_mask;
  logic [7:0]  r;
  logic [15:0] w;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;
  logic        wb;

  assign a  = req.acc_value;
  assign b  = req.src_value;
  assign zf = req.flags_in[FLAG_Z];
  assign nf = req.flags_in[FLAG_N];
  assign hf = req.flags_in[FLAG_H];
  assign cf = req.flags_in[FLAG_C];

  assign ci_adc = (req.req_type == OP_ADC) && cf;
  assign ci_sbc = (req.req_type == OP_SBC) && cf;

  assign sum9    = {1'b0, a} + {1'b0, b} + {8'd0, ci_adc};
  assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_adc};
  assign diff9   = {1'b0, a} - {1'b0, b} - {8'd0, ci_sbc};
  assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sbc};

  assign sum17 = {1'b0, req.wide_dest} + {1'b0, req.wide_src};
  assign sum13 = {1'b0, req.wide_dest[11:0]} + {1'b0, req.wide_src[11:0]};

  // decimal adjust
  assign daa_up = a + ((cf || (a > DAA_HI_LIM)) ? DAA_HI_ADJ : 8'd0)
                    + ((hf || (a[3:0] > DAA_LO_LIM)) ? DAA_LO_ADJ : 8'd0);
  assign daa_dn = a - (cf ? DAA_HI_ADJ : 8'd0) - (hf ? DAA_LO_ADJ : 8'd0);
  assign daa_r  = nf ? daa_dn : daa_up;
  assign daa_c  = cf || (!nf && (a > DAA_HI_LIM));

  assign bit_mask = 8'd1 << req.bit_index;

  always_comb begin
    r  = a;
    w  = 16'd0;
    fz = zf;
    fn = nf;
    fh = hf;
    fc = cf;
    wb = 1'b1;
    case (req.req_type)
      OP_ADD, OP_ADC: begin
        r  = sum9[7:0];
        fz = (sum9[7:0] == 8'd0);
        fn = 1'b0;
        fh = sum_lo[4];
        fc = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (req.req_type == OP_CP) begin
          wb = 1'b0;
        end else begin
          r = diff9[7:0];
        end
        fz = (diff9[7:0] == 8'd0);
        fn = 1'b1;
        fh = diff_lo[4];
        fc = diff9[8];
      end
      OP_AND: begin
        r  = a & b;
        fz = ((a & b) == 8'd0);
        fn = 1'b0;
        fh = 1'b1;
        fc = 1'b0;
      end
      OP_XOR: begin
        r  = a ^ b;
        fz = ((a ^ b) == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      OP_OR: begin
        r  = a | b;
        fz = ((a | b) == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      OP_INC: begin
        r  = a + 8'd1;
        fz = (a == 8'hFF);
        fn = 1'b0;
        fh = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r  = a - 8'd1;
        fz = (a == 8'h01);
        fn = 1'b1;
        fh = (a[3:0] == 4'h0);
      end
      OP_DAA: begin
        r  = daa_r;
        fz = (daa_r == 8'd0);
        fh = 1'b0;
        fc = daa_c;
      end
      OP_CPL: begin
        r  = ~a;
        fn = 1'b1;
        fh = 1'b1;
      end
      OP_SCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b1;
      end
      OP_CCF: begin
        fn = 1'b0;
        fh = 1'b0;
        fc = !cf;
      end
      OP_RLCA, OP_RLC: begin
        r  = {a[6:0], a[7]};
        fz = (req.req_type == OP_RLC) && (a == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[7];
      end
      OP_RRCA, OP_RRC: begin
        r  = {a[0], a[7:1]};
        fz = (req.req_type == OP_RRC) && (a == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[0];
      end
      OP_RLA, OP_RL: begin
        r  = {a[6:0], cf};
        fz = (req.req_type == OP_RL) && ({a[6:0], cf} == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[7];
      end
      OP_RRA, OP_RR: begin
        r  = {cf, a[7:1]};
        fz = (req.req_type == OP_RR) && ({cf, a[7:1]} == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[0];
      end
      OP_SLA: begin
        r  = {a[6:0], 1'b0};
        fz = (a[6:0] == 7'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[7];
      end
      OP_SRA: begin
        r  = {a[7], a[7:1]};
        fz = (a[7:1] == 7'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[0];
      end
      OP_SWAP: begin
        r  = {a[3:0], a[7:4]};
        fz = (a == 8'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = 1'b0;
      end
      OP_SRL: begin
        r  = {1'b0, a[7:1]};
        fz = (a[7:1] == 7'd0);
        fn = 1'b0;
        fh = 1'b0;
        fc = a[0];
      end
      OP_BIT: begin
        fz = ((a & bit_mask) == 8'd0);
        fn = 1'b0;
        fh = 1'b1;
        wb = 1'b0;
      end
      OP_RES: begin
        r = a & ~bit_mask;
      end
      OP_SET: begin
        r = a | bit_mask;
      end
      OP_ADD16: begin
        r  = 8'd0;
        w  = sum17[15:0];
        fn = 1'b0;
        fh = sum13[12];
        fc = sum17[16];
      end
      default: begin
        // codes with no operation pass the byte and flags through
        wb = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp.result_value      = r;
    rsp.wide_result       = w;
    rsp.flags_out         = 4'd0;
    rsp.flags_out[FLAG_Z] = fz;
    rsp.flags_out[FLAG_N] = fn;
    rsp.flags_out[FLAG_H] = fh;
    rsp.flags_out[FLAG_C] = fc;
    rsp.writes_back       = wb;
  end

endmodule

`default_nettype wire

>>> rtl/core/ebalu_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ebalu_out_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load_valid,
  output logic                 load_take,
  input  wire ebalu_pkg::rsp_t load_word,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ebalu_pkg::rsp_t      out_word
);
  import ebalu_pkg::*;

  logic out_valid_next;

  assign load_take = load_valid && (!out_valid || out_ready);

  always_comb begin
    out_valid_next = out_valid;
    if (!out_valid || out_ready) begin
      out_valid_next = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      out_word <= load_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ebalu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ebalu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [4:0]  req_type,
  input wire logic [7:0]  acc_value,
  input wire logic [7:0]  src_value,
  input wire logic [2:0]  bit_index,
  input wire logic [3:0]  flags_in,
  input wire logic [15:0] wide_dest,
  input wire logic [15:0] wide_src,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  result_value,
  input wire logic [15:0] wide_result,
  input wire logic [3:0]  flags_out,
  input wire logic        writes_back
);

  // nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value)
      && $stable(wide_result) && $stable(flags_out) && $stable(writes_back))
    else $error("stalled result word changed");

  // with an empty result register the block always takes input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // only the wide add gives a nonzero wide result, and it clears the byte
  a_wide_only_add16: assert property (@(posedge clk) disable iff (rst)
    out_valid && (wide_result != 16'd0) |-> (result_value == 8'd0) && writes_back)
    else $error("wide result on a byte operation");

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ebalu_pkg::*;

  // codes that the package leaves unnamed; the block must pass them through
  localparam logic [4:0] OP_UNUSED_LO = 5'd30;
  localparam logic [4:0] OP_UNUSED_HI = 5'd31;

  localparam int STALL_CYCLES  = 200;  // long output hold-off
  localparam int STALL_WORDS   = 40;   // words offered while the output is held
  localparam int SETTLE_CYCLES = 8;    // wait after the final drain for a late stray word
  localparam int RANDOM_WORDS  = 430;  // per idle mix

  // operand values that sit on carry, half-carry and decimal-adjust edges
  localparam logic [7:0] BYTE_CORNERS [8] = '{
    8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h99, 8'h9A
  };
  localparam logic [15:0] WIDE_CORNERS [6] = '{
    16'h0000, 16'hFFFF, 16'h0FFF, 16'h0001, 16'hF000, 16'h8000
  };

  // one accepted input word and the result word it must produce
  typedef struct {
    req_t word;
    rsp_t result;
  } pending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  req_type = '0;
  logic [7:0]  acc_value = '0;
  logic [7:0]  src_value = '0;
  logic [2:0]  bit_index = '0;
  logic [3:0]  flags_in = '0;
  logic [15:0] wide_dest = '0;
  logic [15:0] wide_src = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  result_value;
  logic [15:0] wide_result;
  logic [3:0]  flags_out;
  logic        writes_back;

  pending_t    pending_q[$];     // results still owed by the block, oldest first
  pending_t    head;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        rx_hold = 1'b0;   // forces out_ready low during the long stall
  int          errors = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  bit [31:0]   codes_hit = '0;

  eight_bit_alu_with_flags i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .acc_value    (acc_value),
    .src_value    (src_value),
    .bit_index    (bit_index),
    .flags_in     (flags_in),
    .wide_dest    (wide_dest),
    .wide_src     (wide_src),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .wide_result  (wide_result),
    .flags_out    (flags_out),
    .writes_back  (writes_back)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pack four flag bits at their architectural positions
  function automatic logic [3:0] flag_word(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // expected result word for one input word; the block keeps no state
  function automatic rsp_t alu_predict(req_t w);
    rsp_t        r;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  res;
    logic        z, n, h, c, ci, c2;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    a  = w.acc_value;
    b  = w.src_value;
    z  = w.flags_in[FLAG_Z];
    n  = w.flags_in[FLAG_N];
    h  = w.flags_in[FLAG_H];
    c  = w.flags_in[FLAG_C];
    ci = c;
    // defaults: byte passes through, flags kept, no wide sum, written back
    r.result_value = a;
    r.wide_result  = '0;
    r.flags_out    = w.flags_in;
    r.writes_back  = 1'b1;
    case (w.req_type)
      OP_ADD, OP_ADC: begin
        if (w.req_type == OP_ADD) ci = 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + ci;
        sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + ci;
        r.result_value = sum9[7:0];
        r.flags_out = flag_word(sum9[7:0] == 8'h00, 1'b0, sum5[4], sum9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (w.req_type != OP_SBC) ci = 1'b0;
        res = a - b - ci;
        r.flags_out = flag_word(res == 8'h00, 1'b1,
                                {1'b0, a[3:0]} < {1'b0, b[3:0]} + ci,
                                {1'b0, a} < {1'b0, b} + ci);
        // compare only sets flags
        if (w.req_type == OP_CP) r.writes_back = 1'b0;
        else r.result_value = res;
      end
      OP_AND: begin
        res = a & b;
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR: begin
        res = a ^ b;
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_OR: begin
        res = a | b;
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        res = a + 8'd1;
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, a[3:0] == 4'hF, c);
      end
      OP_DEC: begin
        res = a - 8'd1;
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b1, a[3:0] == 4'h0, c);
      end
      OP_DAA: begin
        // after an add: correct upward on carries or out-of-range digits;
        // after a subtract: correct downward on the recorded borrows only
        res = a;
        c2  = c;
        if (!n) begin
          if (c || a > DAA_HI_LIM) begin
            res = res + DAA_HI_ADJ;
            c2  = 1'b1;
          end
          if (h || a[3:0] > DAA_LO_LIM) res = res + DAA_LO_ADJ;
        end else begin
          if (c) res = res - DAA_HI_ADJ;
          if (h) res = res - DAA_LO_ADJ;
        end
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, n, 1'b0, c2);
      end
      OP_CPL: begin
        r.result_value = ~a;
        r.flags_out = flag_word(z, 1'b1, 1'b1, c);
      end
      OP_SCF: r.flags_out = flag_word(z, 1'b0, 1'b0, 1'b1);
      OP_CCF: r.flags_out = flag_word(z, 1'b0, 1'b0, !c);
      // accumulator rotates always clear Z; the prefixed forms test the result
      OP_RLCA, OP_RLC: begin
        res = {a[6:0], a[7]};
        r.result_value = res;
        r.flags_out = flag_word(w.req_type == OP_RLC && res == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_RRCA, OP_RRC: begin
        res = {a[0], a[7:1]};
        r.result_value = res;
        r.flags_out = flag_word(w.req_type == OP_RRC && res == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_RLA, OP_RL: begin
        res = {a[6:0], c};
        r.result_value = res;
        r.flags_out = flag_word(w.req_type == OP_RL && res == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_RRA, OP_RR: begin
        res = {c, a[7:1]};
        r.result_value = res;
        r.flags_out = flag_word(w.req_type == OP_RR && res == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SLA: begin
        res = {a[6:0], 1'b0};
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, a[7]);
      end
      OP_SRA: begin
        res = {a[7], a[7:1]};
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_SWAP: begin
        res = {a[3:0], a[7:4]};
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_SRL: begin
        res = {1'b0, a[7:1]};
        r.result_value = res;
        r.flags_out = flag_word(res == 8'h00, 1'b0, 1'b0, a[0]);
      end
      OP_BIT: begin
        r.flags_out   = flag_word(!a[w.bit_index], 1'b0, 1'b1, c);
        r.writes_back = 1'b0;
      end
      OP_RES: r.result_value = a & ~(8'h01 << w.bit_index);
      OP_SET: r.result_value = a | (8'h01 << w.bit_index);
      OP_ADD16: begin
        // half-carry out of bit 11, carry out of bit 15, Z untouched
        sum17 = {1'b0, w.wide_dest} + {1'b0, w.wide_src};
        sum13 = {1'b0, w.wide_dest[11:0]} + {1'b0, w.wide_src[11:0]};
        r.wide_result  = sum17[15:0];
        r.result_value = 8'h00;
        r.flags_out    = flag_word(z, 1'b0, sum13[12], sum17[16]);
      end
      default: r.writes_back = 1'b0;
    endcase
    return r;
  endfunction

  function automatic req_t build_word(logic [4:0] op, logic [7:0] a, logic [7:0] b,
                                      logic [2:0] bi, logic [3:0] f,
                                      logic [15:0] wd, logic [15:0] ws);
    req_t w;
    w.req_type  = op;
    w.acc_value = a;
    w.src_value = b;
    w.bit_index = bi;
    w.flags_in  = f;
    w.wide_dest = wd;
    w.wide_src  = ws;
    return w;
  endfunction

  // a quarter of the bytes land on an edge value
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return BYTE_CORNERS[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_wide();
    if ($urandom_range(0, 4) == 0) return WIDE_CORNERS[$urandom_range(0, 5)];
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic req_t random_word();
    logic [4:0] op;
    // mostly real operations, now and then one of the unused codes
    if ($urandom_range(0, 99) < 4) op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else op = 5'($urandom_range(OP_ADD, OP_ADD16));
    return build_word(op, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                      4'($urandom_range(0, 15)), pick_wide(), pick_wide());
  endfunction

  // offer one word, hold it until taken, then record what it must produce
  task automatic send_word(input req_t w);
    pending_t p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= w.req_type;
    acc_value <= w.acc_value;
    src_value <= w.src_value;
    bit_index <= w.bit_index;
    flags_in  <= w.flags_in;
    wide_dest <= w.wide_dest;
    wide_src  <= w.wide_src;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p.word   = w;
    p.result = alu_predict(w);
    pending_q.push_back(p);
    words_sent++;
    codes_hit[w.req_type] = 1'b1;
  endtask

  // stop offering and wait until the block has returned every owed word
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // byte add and subtract families, carries in and out, all-zero results
  task automatic test_add_sub();
    send_word(build_word(OP_ADD, 8'hFF, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_word(build_word(OP_ADC, 8'h0F, 8'h00, 3'd7, 4'hF, 16'hFFFF, 16'hFFFF));
    send_word(build_word(OP_SUB, 8'h00, 8'h01, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_word(build_word(OP_SBC, 8'h10, 8'h0F, 3'd0, 4'h1, 16'h0000, 16'h0000));
    send_word(build_word(OP_CP,  8'h5A, 8'h5A, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_word(build_word(OP_INC, 8'hFF, 8'h00, 3'd0, 4'h1, 16'h0000, 16'h0000));
    send_word(build_word(OP_DEC, 8'h00, 8'hFF, 3'd0, 4'h0, 16'h0000, 16'h0000));
  endtask

  task automatic test_logic_ops();
    send_word(build_word(OP_AND, 8'hFF, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_XOR, 8'hA5, 8'hA5, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_OR,  8'h00, 8'h80, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_CPL, 8'h00, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
  endtask

  // flag-only ops keep the byte; decimal adjust in both directions
  task automatic test_flag_ops();
    send_word(build_word(OP_SCF, 8'h3C, 8'h00, 3'd0, 4'h8, 16'h0000, 16'h0000));
    send_word(build_word(OP_CCF, 8'h3C, 8'h00, 3'd0, 4'h9, 16'h0000, 16'h0000));
    send_word(build_word(OP_DAA, 8'h9A, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
    send_word(build_word(OP_DAA, 8'h00, 8'h00, 3'd0, 4'h7, 16'h0000, 16'h0000));
  endtask

  // every rotate and shift; bits leaving either end, carry feeding in
  task automatic test_shift_ops();
    for (int op = OP_RLCA; op <= OP_SRL; op++) begin
      if (op % 2 == 0) send_word(build_word(5'(op), 8'h80, 8'h00, 3'd0, 4'h0,
                                            16'h0000, 16'h0000));
      else send_word(build_word(5'(op), 8'h01, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    end
    // sign bit must stay put on an arithmetic right shift
    send_word(build_word(OP_SRA, 8'h81, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
  endtask

  task automatic test_bit_ops();
    send_word(build_word(OP_BIT, 8'h80, 8'h00, 3'd7, 4'h0, 16'h0000, 16'h0000));
    send_word(build_word(OP_BIT, 8'hFE, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_RES, 8'hFF, 8'h00, 3'd7, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_SET, 8'h00, 8'h00, 3'd0, 4'h0, 16'h0000, 16'h0000));
  endtask

  // wide add wraps to zero with both carries; Z comes from the incoming flags
  task automatic test_wide_add();
    send_word(build_word(OP_ADD16, 8'hFF, 8'hFF, 3'd0, 4'h8, 16'hFFFF, 16'h0001));
  endtask

  task automatic test_unused_codes();
    send_word(build_word(OP_UNUSED_LO, 8'hFF, 8'h00, 3'd0, 4'hF, 16'h0000, 16'h0000));
    send_word(build_word(OP_UNUSED_HI, 8'h00, 8'hFF, 3'd7, 4'h0, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_random_traffic(input int n_words, input int tx_idle, input int rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (n_words) send_word(random_word());
    drain_results();
  endtask

  // hold the output off long enough that the block fills and stops taking words
  task automatic test_result_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (STALL_WORDS) send_word(random_word());
    join
    drain_results();
  endtask

  // result side: check each accepted word against the oldest prediction,
  // then pick out_ready for the next edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none pending: expected nothing, actual %h %h %h %b",
                 $time, result_value, wide_result, flags_out, writes_back);
      end else begin
        head = pending_q.pop_front();
        if (result_value !== head.result.result_value) begin
          errors++;
          $display("%0t: op %0d result_value expected %h actual %h", $time,
                   head.word.req_type, head.result.result_value, result_value);
        end
        if (wide_result !== head.result.wide_result) begin
          errors++;
          $display("%0t: op %0d wide_result expected %h actual %h", $time,
                   head.word.req_type, head.result.wide_result, wide_result);
        end
        if (flags_out !== head.result.flags_out) begin
          errors++;
          $display("%0t: op %0d flags_out expected %b actual %b", $time,
                   head.word.req_type, head.result.flags_out, flags_out);
        end
        if (writes_back !== head.result.writes_back) begin
          errors++;
          $display("%0t: op %0d writes_back expected %b actual %b", $time,
                   head.word.req_type, head.result.writes_back, writes_back);
        end
      end
    end
    out_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    // reset once
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed words under the first idle mix
    send_idle_pct = 30;
    recv_idle_pct = 46;
    test_add_sub();
    test_logic_ops();
    test_flag_ops();
    test_shift_ops();
    test_bit_ops();
    test_wide_add();
    test_unused_codes();
    drain_results();

    // random words: receiver idles more, then sender idles more, then no gaps
    test_random_traffic(RANDOM_WORDS, 30, 46);
    test_random_traffic(RANDOM_WORDS, 46, 30);
    test_random_traffic(RANDOM_WORDS, 0, 0);
    test_result_stall();

    // nothing owed any more; give a late stray word time to show up
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words over %0d of 32 operation codes, %0d results checked",
             words_sent, $countones(codes_hit), results_seen);
    $display("idle mixes 30/46, 46/30 and none, a %0d-cycle output stall, full drains",
             STALL_CYCLES);
    if (errors == 0) begin
      $display("eight_bit_alu_with_flags regression: pass");
    end else begin
      $display("eight_bit_alu_with_flags regression: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d words still owed", pending_q.size());
    $display("eight_bit_alu_with_flags regression: fail");
    $finish;
  end

endmodule

>>> eight_bit_alu_with_flags.f
rtl/core/ebalu_pkg.sv
rtl/core/ebalu_in_stage.sv
rtl/core/ebalu_exec.sv
rtl/core/ebalu_out_stage.sv
rtl/core/eight_bit_alu_with_flags.sv
rtl/core/ebalu_checker.sv
test/tb_top.sv
